// File: rtl/tst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the transfer session table.
// No dependencies; imported by every module of the block.
package tst_pkg;

	// Table geometry and message limits
	localparam int ENTRIES  = 32;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MAX_MSG  = 1500;
	localparam int LEN_W    = 11;
	localparam int SLOT_W   = 5;

	localparam logic [7:0]       CTRL_MARK = 8'hFF;
	localparam logic [LEN_W-1:0] CTRL_LEN  = LEN_W'(3);
	localparam logic [LEN_W-1:0] MIN_LEN   = LEN_W'(2);
	localparam logic [LEN_W-1:0] HDR_LEN   = LEN_W'(2);
	localparam logic [31:0]      SIZE_LEN  = 32'd4;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OPENED    = 3'd0,
		ST_FULL      = 3'd1,
		ST_UNKNOWN   = 3'd2,
		ST_SIZE      = 3'd3,
		ST_DATA      = 3'd4,
		ST_DONE      = 3'd5,
		ST_MALFORMED = 3'd6
	} status_t;

	// Input transaction: one message header
	typedef struct packed {
		logic [LEN_W-1:0] msg_len;
		logic [7:0]       head_byte;
		logic [7:0]       second_byte;
		logic [31:0]      lead_word;
	} hdr_t;

	// Output transaction
	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       received_total;
		logic [31:0]       expected_total;
	} result_t;

	// Per-slot byte counters held in the counter memory
	typedef struct packed {
		logic [31:0] expected;
		logic [31:0] received;
	} counts_t;

	// Controller state
	typedef enum logic {
		S_IDLE,
		S_WORK
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

// File: rtl/tst_ctrl.sv
`timescale 1ns / 1ps
// Controller for the transfer session table: sequences capture and commit.
// Depends on tst_pkg.
module tst_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	output tst_pkg::cmd_t cmd
);
	import tst_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_WORK);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_WORK;
			end
			S_WORK: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Drive commands and handshake
	always_comb begin
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		busy        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = start;
			end
			S_WORK: begin
				cmd.commit = 1'b1;
				busy       = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	assign done = done_q;

endmodule

// File: rtl/tst_datapath.sv
`timescale 1ns / 1ps
// Datapath for the transfer session table: slot match, counter memory, update.
// Depends on tst_pkg; driven by tst_ctrl commands.
module tst_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  tst_pkg::cmd_t   cmd,
	input  tst_pkg::hdr_t   hdr,
	output tst_pkg::result_t result
);
	import tst_pkg::*;

	// Slot keys and occupancy
	logic [ENTRIES-1:0] valid_q;
	logic [7:0]         node_q [ENTRIES];
	logic [7:0]         port_q [ENTRIES];
	// Counter memory
	counts_t            cnt_mem [ENTRIES];

	// Captured transaction
	hdr_t               hdr_q;
	logic               malformed_q;
	logic               ctrl_q;
	logic               hit_q;
	logic [IDX_W-1:0]   idx_q;
	counts_t            cnt_q;
	result_t            result_q;

	// Lookup signals
	logic               malformed;
	logic               ctrl;
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] sel;
	logic [ENTRIES-1:0] lowest;
	logic [IDX_W-1:0]   idx;

	// Update signals
	logic [31:0]        plen;
	logic [31:0]        recv_sum;
	result_t            res;
	counts_t            cnt_wr;
	logic               cnt_we;
	logic               open_slot;
	logic               close_slot;

	// Classify the incoming header
	assign malformed = (hdr.msg_len < MIN_LEN) || (hdr.msg_len > LEN_W'(MAX_MSG));
	assign ctrl      = (hdr.head_byte == CTRL_MARK) && (hdr.msg_len == CTRL_LEN);

	// Compare key against every slot
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (node_q[i] == hdr.head_byte)
				&& (port_q[i] == hdr.second_byte);
		end
	end

	// Pick the lowest free or matching slot
	assign sel    = ctrl ? ~valid_q : match;
	assign lowest = sel & (~sel + ENTRIES'(1));

	always_comb begin
		idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (lowest[i]) idx = idx | IDX_W'(i);
		end
	end

	// Capture the transaction and the chosen slot
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hdr_q       <= hdr;
			malformed_q <= malformed;
			ctrl_q      <= ctrl;
			hit_q       <= |sel;
			idx_q       <= idx;
		end
	end

	// Counter memory: read on capture, write on commit
	always_ff @(posedge clk) begin
		if (cmd.capture) cnt_q <= cnt_mem[idx];
		if (cmd.commit && cnt_we) cnt_mem[idx_q] <= cnt_wr;
	end

	// Compute the update and the result
	assign plen     = 32'(hdr_q.msg_len - HDR_LEN);
	assign recv_sum = cnt_q.received + plen;

	always_comb begin
		res            = '0;
		res.status     = ST_MALFORMED;
		cnt_wr         = cnt_q;
		cnt_we         = 1'b0;
		open_slot      = 1'b0;
		close_slot     = 1'b0;
		if (malformed_q) begin
			res.status = ST_MALFORMED;
		end else if (ctrl_q) begin
			if (hit_q) begin
				res.status = ST_OPENED;
				res.slot   = SLOT_W'(idx_q);
				cnt_wr     = '0;
				cnt_we     = 1'b1;
				open_slot  = 1'b1;
			end else begin
				res.status = ST_FULL;
			end
		end else if (!hit_q) begin
			res.status = ST_UNKNOWN;
		end else if ((cnt_q.expected == 32'd0) && (plen == SIZE_LEN)) begin
			// Record the announced size
			cnt_wr.expected    = hdr_q.lead_word;
			cnt_we             = 1'b1;
			res.status         = ST_SIZE;
			res.slot           = SLOT_W'(idx_q);
			res.received_total = cnt_q.received;
			res.expected_total = hdr_q.lead_word;
		end else begin
			// Count payload bytes, free the slot once complete
			cnt_wr.received    = recv_sum;
			cnt_we             = 1'b1;
			res.slot           = SLOT_W'(idx_q);
			res.received_total = recv_sum;
			res.expected_total = cnt_q.expected;
			if ((cnt_q.expected != 32'd0) && (recv_sum >= cnt_q.expected)) begin
				res.status = ST_DONE;
				close_slot = 1'b1;
			end else begin
				res.status = ST_DATA;
			end
		end
	end

	// Occupancy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			if (open_slot)  valid_q[idx_q] <= 1'b1;
			if (close_slot) valid_q[idx_q] <= 1'b0;
		end
	end

	// Slot keys
	always_ff @(posedge clk) begin
		if (cmd.commit && open_slot) begin
			node_q[idx_q] <= hdr_q.second_byte;
			port_q[idx_q] <= hdr_q.lead_word[31:24];
		end
	end

	// Hold the result for the output strobe
	always_ff @(posedge clk) begin
		if (cmd.commit) result_q <= res;
	end

	assign result = result_q;

endmodule

// File: rtl/transfer_session_table_core.sv
`timescale 1ns / 1ps
// Top level of the transfer session table.
// Depends on tst_pkg, tst_ctrl and tst_datapath.
//
// For each transaction, at the accepting edge the header is
// compared against all slot keys in parallel, the lowest free or matching slot
// is picked by a priority encoder, and that slot's counters are read from the
// counter memory; in the following cycle (busy high) the counters are updated
// and written back through the memory's single write port. The result is
// shown for one cycle with done high right after that, and a new transaction
// may be accepted in that same cycle. The receiver cannot stall; every
// transaction yields exactly one result. No clearing pass follows reset: slot
// occupancy flags clear at once.
module transfer_session_table_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tst_pkg::hdr_t    hdr,
	output logic             done,
	output tst_pkg::result_t result
);
	import tst_pkg::*;

	cmd_t cmd;

	tst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	tst_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.hdr    (hdr),
		.result (result)
	);

endmodule

// File: rtl/tst_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the transfer session table, bound to the top level.
// Depends on tst_pkg.
module tst_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input tst_pkg::result_t result
);
	import tst_pkg::*;

	// Accepted transaction occupies the block for one cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// Busy lasts one cycle and is followed by the result
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (!busy && done))
		else $error("busy cycle not followed by result strobe");

	// Every result follows a busy cycle
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding transaction");

	// Results without a slot report zero slot and counts
	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_FULL || result.status == ST_UNKNOWN
			|| result.status == ST_MALFORMED))
		|-> (result.slot == '0 && result.received_total == '0
			&& result.expected_total == '0))
		else $error("slotless result carries nonzero fields");

endmodule

bind transfer_session_table_core tst_checker u_tst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// File: tb/sv/transfer_session_table_check.sv
`timescale 1ns / 1ps
// Checker for the transfer session table: predicts each result and compares it.
// Depends on tst_pkg; instantiated beside the block by the testbench top.
module transfer_session_table_check (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  tst_pkg::hdr_t    hdr,
	input  logic             done,
	input  tst_pkg::result_t result,
	input  logic             closing,
	output int               errors,
	output int               pending
);
	import tst_pkg::*;

	// Shadow copy of the session table
	bit          slot_live [ENTRIES];
	logic [7:0]  slot_node [ENTRIES];
	logic [7:0]  slot_port [ENTRIES];
	logic [31:0] slot_want [ENTRIES];
	logic [31:0] slot_got  [ENTRIES];

	result_t awaited [$];
	result_t want;
	bit      closed;

	// Count a mismatch; keep the log short when the block is badly off
	task automatic report(input string what);
		errors++;
		if (errors <= 40)
			$display("check: %s", what);
	endtask

	// Apply one header to the shadow table and return the result it causes
	function automatic result_t track_header(input hdr_t h);
		result_t     r;
		int          hit;
		logic [31:0] plen;
		r = '0;
		hit = -1;
		if (h.msg_len < MIN_LEN || h.msg_len > MAX_MSG) begin
			r.status = ST_MALFORMED;
			return r;
		end
		// Control message: open in the lowest free slot
		if (h.head_byte == CTRL_MARK && h.msg_len == CTRL_LEN) begin
			for (int i = ENTRIES - 1; i >= 0; i--)
				if (!slot_live[i])
					hit = i;
			if (hit < 0) begin
				r.status = ST_FULL;
				return r;
			end
			slot_live[hit] = 1'b1;
			slot_node[hit] = h.second_byte;
			slot_port[hit] = h.lead_word[31:24];
			slot_want[hit] = '0;
			slot_got[hit]  = '0;
			r.status = ST_OPENED;
			r.slot   = SLOT_W'(hit);
			return r;
		end
		// Data: lowest matching slot wins
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (slot_live[i] && slot_node[i] == h.head_byte && slot_port[i] == h.second_byte)
				hit = i;
		if (hit < 0) begin
			r.status = ST_UNKNOWN;
			return r;
		end
		plen = 32'(h.msg_len) - 32'(HDR_LEN);
		r.slot = SLOT_W'(hit);
		if (slot_want[hit] == '0 && plen == SIZE_LEN) begin
			slot_want[hit] = h.lead_word;
			r.status = ST_SIZE;
		end else begin
			slot_got[hit] = slot_got[hit] + plen;
			if (slot_want[hit] != '0 && slot_got[hit] >= slot_want[hit]) begin
				slot_live[hit] = 1'b0;
				r.status = ST_DONE;
			end else begin
				r.status = ST_DATA;
			end
		end
		r.received_total = slot_got[hit];
		r.expected_total = slot_want[hit];
		return r;
	endfunction

	// Match results against predictions, then record the new transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				slot_live[i] = 1'b0;
			awaited.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (awaited.size() == 0) begin
					report($sformatf("result with no transaction waiting at %0t", $time));
				end else begin
					want = awaited.pop_front();
					if (result.status !== want.status)
						report($sformatf("status %0d, want %0d at %0t",
							result.status, want.status, $time));
					if (result.slot !== want.slot)
						report($sformatf("slot %0d, want %0d at %0t",
							result.slot, want.slot, $time));
					if (result.received_total !== want.received_total)
						report($sformatf("received %0h, want %0h at %0t",
							result.received_total, want.received_total, $time));
					if (result.expected_total !== want.expected_total)
						report($sformatf("expected %0h, want %0h at %0t",
							result.expected_total, want.expected_total, $time));
				end
			end
			if (start && !busy)
				awaited.push_back(track_header(hdr));
			// Drop and flag whatever never arrived
			if (closing && !closed) begin
				while (awaited.size() != 0) begin
					void'(awaited.pop_front());
					report("transaction left without a result");
				end
				closed = 1'b1;
			end
			pending <= awaited.size();
		end
	end

endmodule

// File: tb/sv/transfer_session_table_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the transfer session table: drives message headers and gives the verdict.
// Depends on tst_pkg, transfer_session_table_core and transfer_session_table_check.
module transfer_session_table_core_test;
	import tst_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 500;

	// Sender-side view of a transfer in progress
	typedef struct {
		logic [7:0] node;
		logic [7:0] port;
		bit         sized;
		int         left;
	} session_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	hdr_t    hdr;
	logic    done;
	result_t result;
	logic    closing;
	int      errors;
	int      pending;

	int       idle_pct;
	int       quiet_cycles;
	session_t live [$];

	transfer_session_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.hdr    (hdr),
		.done   (done),
		.result (result)
	);

	transfer_session_table_check audit (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.hdr     (hdr),
		.done    (done),
		.result  (result),
		.closing (closing),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic hdr_t mk_hdr(input logic [LEN_W-1:0] len, input logic [7:0] head,
			input logic [7:0] second, input logic [31:0] word);
		hdr_t h;
		h.msg_len     = len;
		h.head_byte   = head;
		h.second_byte = second;
		h.lead_word   = word;
		return h;
	endfunction

	// Present one transaction, hold it until taken, then maybe idle
	task automatic issue(input hdr_t h);
		start <= 1'b1;
		hdr   <= h;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Hold off until every result has come back
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic open_session(input logic [7:0] node, input logic [7:0] port);
		session_t s;
		s.node  = node;
		s.port  = port;
		s.sized = 1'b0;
		s.left  = 0;
		issue(mk_hdr(CTRL_LEN, CTRL_MARK, node, {port, 24'($urandom)}));
		live.push_back(s);
		if (live.size() > 64)
			void'(live.pop_front());
	endtask

	// One random transaction: mostly well-formed transfers, some noise
	task automatic random_item();
		int          r;
		int          k;
		int          plen;
		logic [31:0] sz;
		session_t    s;
		r = $urandom_range(99);
		if (r < 8) begin
			issue(mk_hdr(LEN_W'($urandom), 8'($urandom), 8'($urandom), $urandom));
		end else if (r < 12) begin
			if ($urandom_range(1) == 0)
				issue(mk_hdr(LEN_W'($urandom_range(1)), 8'($urandom), 8'($urandom), $urandom));
			else
				issue(mk_hdr(LEN_W'($urandom_range(MAX_MSG + 1, 2047)), 8'($urandom),
					8'($urandom), $urandom));
		end else if (r < 16) begin
			issue(mk_hdr(LEN_W'($urandom_range(2, MAX_MSG)), 8'($urandom), 8'($urandom),
				$urandom));
		end else if (r < 28 || live.size() < 4) begin
			// Mostly fresh keys, now and then a duplicate
			if (live.size() != 0 && $urandom_range(99) < 3) begin
				s = live[$urandom_range(live.size() - 1)];
				open_session(s.node, s.port);
			end else begin
				open_session(8'($urandom), 8'($urandom));
			end
		end else begin
			k = $urandom_range(live.size() - 1);
			s = live[k];
			if (!s.sized && $urandom_range(99) < 15) begin
				// Data ahead of the size word
				plen = $urandom_range(20);
				if (plen == 4 || (s.node == CTRL_MARK && plen == 1))
					plen = 5;
				issue(mk_hdr(LEN_W'(plen + 2), s.node, s.port, $urandom));
			end else if (!s.sized) begin
				r = $urandom_range(99);
				if (r < 3)
					sz = '0;
				else if (r < 5)
					sz = $urandom;
				else
					sz = 32'($urandom_range(1, 4000));
				issue(mk_hdr(LEN_W'(6), s.node, s.port, sz));
				if (r >= 5) begin
					live[k].sized = 1'b1;
					live[k].left  = int'(sz);
				end else if (sz != '0) begin
					live.delete(k);
				end
			end else begin
				if ($urandom_range(99) < 85)
					plen = $urandom_range((s.left < MAX_MSG - 2) ? s.left : MAX_MSG - 2);
				else
					plen = $urandom_range(MAX_MSG - 2);
				if (s.node == CTRL_MARK && plen == 1)
					plen = 2;
				issue(mk_hdr(LEN_W'(plen + 2), s.node, s.port, $urandom));
				live[k].left = s.left - plen;
				if (live[k].left <= 0)
					live.delete(k);
			end
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		hdr      = '0;
		closing  = 1'b0;
		idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: length limits, unknown sender, control corner cases, completion
		issue(mk_hdr(LEN_W'(0), 8'h00, 8'h00, 32'h0));
		issue(mk_hdr(LEN_W'(1), CTRL_MARK, 8'hFF, 32'hFFFF_FFFF));
		issue(mk_hdr(LEN_W'(MAX_MSG + 1), 8'h12, 8'h34, 32'h0));
		issue(mk_hdr(LEN_W'(2047), CTRL_MARK, 8'hFF, 32'hFFFF_FFFF));
		issue(mk_hdr(LEN_W'(2), 8'h00, 8'h00, 32'h0));
		issue(mk_hdr(CTRL_LEN, CTRL_MARK, 8'h12, 32'h34A5_5A01));
		issue(mk_hdr(CTRL_LEN, CTRL_MARK, 8'hFF, 32'hFFFF_FFFF));
		// Control mark with a long length counts as data from node 0xFF
		issue(mk_hdr(LEN_W'(MAX_MSG), CTRL_MARK, 8'hFF, 32'h0));
		issue(mk_hdr(LEN_W'(6), CTRL_MARK, 8'hFF, 32'h0));
		issue(mk_hdr(LEN_W'(6), CTRL_MARK, 8'hFF, 32'd1500));
		issue(mk_hdr(LEN_W'(2), CTRL_MARK, 8'hFF, 32'h0));
		issue(mk_hdr(LEN_W'(4), CTRL_MARK, 8'hFF, 32'h0));
		issue(mk_hdr(LEN_W'(6), 8'h12, 8'h34, 32'd3));
		issue(mk_hdr(LEN_W'(7), 8'h12, 8'h34, 32'h0));
		// Duplicate key: the lower slot takes traffic until it completes
		issue(mk_hdr(CTRL_LEN, CTRL_MARK, 8'h00, 32'h0));
		issue(mk_hdr(CTRL_LEN, CTRL_MARK, 8'h00, 32'h0));
		issue(mk_hdr(LEN_W'(6), 8'h00, 8'h00, 32'd5));
		issue(mk_hdr(LEN_W'(6), 8'h00, 8'h00, 32'hFFFF_FFFF));
		issue(mk_hdr(LEN_W'(6), 8'h00, 8'h00, 32'h0));
		issue(mk_hdr(LEN_W'(6), 8'h00, 8'h00, 32'd2));
		issue(mk_hdr(LEN_W'(8), 8'h00, 8'h00, 32'h0));
		issue(mk_hdr(LEN_W'(2), 8'h00, 8'h00, 32'h0));
		wait_drained();

		// Random phases; odd phases start by flooding the table past full
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 74 : (ph == 3) ? 36 : 0;
			if (ph % 2 == 1)
				repeat (ENTRIES + 2) open_session(8'($urandom), 8'($urandom));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				random_item();
				if ($urandom_range(199) == 0)
					wait_drained();
			end
			wait_drained();
		end

		// Let the pipeline settle, then flag anything left over
		repeat (4) @(posedge clk);
		closing <= 1'b1;
		repeat (2) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
